// File: rtl/wbb_pkg.sv
// Package for the wrapped box blur unit: sizes, register indexes, state codes.
// No dependencies.
package wbb_pkg;
  localparam int MaxWidthDef  = 512;
  localparam int MaxHeightDef = 512;
  localparam int SizeStep     = 250;
  localparam int LevelMax     = 30;

  localparam logic [1:0] RegWidth  = 2'd0;
  localparam logic [1:0] RegHeight = 2'd1;
  localparam logic [1:0] RegLevel  = 2'd2;
  localparam logic [1:0] RegSource = 2'd3;

  localparam logic CmdLoad = 1'b0;
  localparam logic CmdBlur = 1'b1;

  typedef enum logic [3:0] {
    S_IDLE, S_MOD, S_SETUP, S_START, S_SCAN, S_DRAIN, S_LAUNCH, S_DIV, S_OUT
  } state_t;
endpackage

// File: rtl/wbb_divider.sv
// Restoring divider for the four channel sums; one quotient bit per cycle.
// Depends on nothing but its ports.
module wbb_divider #(
  parameter int NW = 28,
  parameter int DW = 24
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  input  logic [NW-1:0] numer,
  input  logic [DW-1:0] denom,
  output logic          done,
  output logic [NW-1:0] quot
);
  localparam int CW = $clog2(NW + 1);
  logic [NW-1:0] rem;
  logic [NW-1:0] q;
  logic [CW-1:0] cnt;
  logic          busy;
  logic [NW:0]   trial;

  assign trial = {rem[NW-1:0], q[NW-1]};
  assign quot  = q;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= CW'(NW);
        rem  <= '0;
        q    <= numer;
      end else if (busy) begin
        if (trial >= (NW+1)'(denom)) begin
          rem <= NW'(trial - (NW+1)'(denom));
          q   <= {q[NW-2:0], 1'b1};
        end else begin
          rem <= trial[NW-1:0];
          q   <= {q[NW-2:0], 1'b0};
        end
        cnt <= cnt - 1'b1;
        if (cnt == CW'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end
endmodule

// File: rtl/wrapped_box_blur_rgba_unit.sv
// Wrapped box blur unit: frame memory, window scan sequencer, output register.
// Depends on wbb_pkg and wbb_divider.
//
// Usage: the in channel (in_valid/in_stall) takes one word per item. A load
// word (command 0) writes one RGBA pixel into the frame memory and gives no
// result. A blur word (command 1) scans the wrapped window of 2nx by 2ny
// pixels, one memory read per cycle, then divides the four sums in parallel
// with four bit-serial dividers, and offers one word on the out channel
// (out_valid/out_stall).
// The blur time is set by the window scan through the single read port, by
// the 28-step divide, and by the repeated subtractions that reduce the query
// coordinate and the radius into the frame.
// A level of zero or no source skips the scan and the divide.
// Inputs are taken only while no item is in work; one result stays in the
// output register while the receiver stalls, and the next word waits for it.
// Reset puts the registers at their defaults (256, 256, 5, 1) and idles the
// sequencer; frame contents are undefined until loaded.
module wrapped_box_blur_rgba_unit #(
  parameter int MAX_WIDTH  = wbb_pkg::MaxWidthDef,
  parameter int MAX_HEIGHT = wbb_pkg::MaxHeightDef
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_we,
  input  logic [1:0] cfg_index,
  input  logic [9:0] cfg_data,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic       command,
  input  logic [8:0] pixel_x,
  input  logic [8:0] pixel_y,
  input  logic [7:0] in_red,
  input  logic [7:0] in_green,
  input  logic [7:0] in_blue,
  input  logic [7:0] in_alpha,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] out_red,
  output logic [7:0] out_green,
  output logic [7:0] out_blue,
  output logic [7:0] out_alpha
);
  localparam int XW = $clog2(MAX_WIDTH) > 0 ? $clog2(MAX_WIDTH) : 1;
  localparam int YW = $clog2(MAX_HEIGHT) > 0 ? $clog2(MAX_HEIGHT) : 1;
  localparam int AW = XW + YW;
  localparam int DEPTH = 2 ** AW;
  localparam int SW = 28;  // 255 * 4 * 300 * 300 < 2^27
  localparam int NWW = 9;  // nx up to 30*2 = 60... padded

  logic [9:0] image_width, image_height;
  logic [4:0] blur_level;
  logic       source_present;

  always_ff @(posedge clk) begin
    if (rst) begin
      image_width    <= 10'd256;
      image_height   <= 10'd256;
      blur_level     <= 5'd5;
      source_present <= 1'b1;
    end else if (cfg_we) begin
      case (cfg_index)
        wbb_pkg::RegWidth:  image_width    <= cfg_data;
        wbb_pkg::RegHeight: image_height   <= cfg_data;
        wbb_pkg::RegLevel:  blur_level     <= cfg_data[4:0];
        wbb_pkg::RegSource: source_present <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // effective sizes
  logic [12:0] w_eff, h_eff;
  assign w_eff = (image_width == 10'd0) ? 13'd1 :
                 (13'(image_width) > 13'(MAX_WIDTH)) ? 13'(MAX_WIDTH) : 13'(image_width);
  assign h_eff = (image_height == 10'd0) ? 13'd1 :
                 (13'(image_height) > 13'(MAX_HEIGHT)) ? 13'(MAX_HEIGHT) : 13'(image_height);
  logic [4:0] lvl;
  assign lvl = (blur_level > 5'(wbb_pkg::LevelMax)) ? 5'(wbb_pkg::LevelMax) : blur_level;
  logic [2:0] fx, fy;  // size/250, at least 1, for sizes below 1024
  assign fx = (w_eff >= 13'd1000) ? 3'd4 : (w_eff >= 13'd750) ? 3'd3 :
              (w_eff >= 13'd500) ? 3'd2 : 3'd1;
  assign fy = (h_eff >= 13'd1000) ? 3'd4 : (h_eff >= 13'd750) ? 3'd3 :
              (h_eff >= 13'd500) ? 3'd2 : 3'd1;

  // frame memory
  logic [31:0] mem [DEPTH];
  logic        mem_we;
  logic [AW-1:0] wr_addr, rd_addr;
  logic [31:0] wr_data, rd_data;
  always_ff @(posedge clk) begin
    if (mem_we) mem[wr_addr] <= wr_data;
    rd_data <= mem[rd_addr];
  end

  wbb_pkg::state_t state, state_next;
  logic [12:0] px, py, nx, ny, cx, cy, sx, i, j;
  logic        zero_res, pass;
  logic [SW-1:0] sum [4];
  logic [23:0]   cnt;
  logic          rd_ok, acc_en, acc_last;
  logic [7:0]    res [4];
  logic          div_start;
  logic [3:0]    div_done;
  logic [SW-1:0] quot [4];

  logic accept;
  assign in_stall = (state != wbb_pkg::S_IDLE) || out_valid;
  assign accept   = in_valid && !in_stall;

  assign mem_we  = accept && command == wbb_pkg::CmdLoad &&
                   (32'(pixel_x) < 32'(MAX_WIDTH)) && (32'(pixel_y) < 32'(MAX_HEIGHT));
  assign wr_addr = {YW'(pixel_y), XW'(pixel_x)};
  assign wr_data = {in_alpha, in_blue, in_green, in_red};
  assign rd_addr = {YW'(cy), XW'(cx)};

  always_comb begin
    state_next = state;
    case (state)
      wbb_pkg::S_IDLE:   if (accept && command == wbb_pkg::CmdBlur)
                           state_next = wbb_pkg::S_MOD;
      wbb_pkg::S_MOD:    if (px < w_eff && py < h_eff) state_next = wbb_pkg::S_SETUP;
      wbb_pkg::S_SETUP:  if (nx < w_eff && ny < h_eff) state_next = wbb_pkg::S_START;
      wbb_pkg::S_START:  state_next = (zero_res || pass) ? wbb_pkg::S_DRAIN : wbb_pkg::S_SCAN;
      wbb_pkg::S_SCAN:   if (i == 13'd0 && j == 13'd0) state_next = wbb_pkg::S_DRAIN;
      wbb_pkg::S_DRAIN:  state_next = (zero_res || pass) ? wbb_pkg::S_OUT : wbb_pkg::S_LAUNCH;
      wbb_pkg::S_LAUNCH: state_next = wbb_pkg::S_DIV;
      wbb_pkg::S_DIV:    if (div_done[0]) state_next = wbb_pkg::S_OUT;
      wbb_pkg::S_OUT:    state_next = wbb_pkg::S_IDLE;
      default:           state_next = wbb_pkg::S_IDLE;
    endcase
  end

  // the last read lands in the sums during drain, so the divide starts after it
  always_comb begin
    div_start = 1'b0;
    rd_ok = 1'b0;
    case (state)
      wbb_pkg::S_SCAN:   rd_ok = 1'b1;
      wbb_pkg::S_LAUNCH: div_start = 1'b1;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= wbb_pkg::S_IDLE;
    else state <= state_next;
  end

  // datapath
  always_ff @(posedge clk) begin
    acc_en   <= rd_ok;
    acc_last <= state == wbb_pkg::S_SCAN && state_next == wbb_pkg::S_DRAIN;
    case (state)
      wbb_pkg::S_IDLE: begin
        px <= 13'(pixel_x);
        py <= 13'(pixel_y);
        zero_res <= !source_present;
        pass <= lvl == 5'd0;
        nx <= 13'(lvl) * 13'(fx);
        ny <= 13'(lvl) * 13'(fy);
        for (int c = 0; c < 4; c++) sum[c] <= '0;
      end
      wbb_pkg::S_MOD: begin
        // reduce query coordinate by repeated subtraction
        if (px >= w_eff) px <= px - w_eff;
        if (py >= h_eff) py <= py - h_eff;
        cnt <= 24'(nx * ny) << 2;
      end
      wbb_pkg::S_SETUP: begin
        if (nx >= w_eff) nx <= nx - w_eff;
        if (ny >= h_eff) ny <= ny - h_eff;
      end
      wbb_pkg::S_START: begin
        if (pass) begin
          cx <= px; cy <= py; sx <= px;
        end else begin
          cx <= (px >= nx) ? px - nx : px + w_eff - nx;
          sx <= (px >= nx) ? px - nx : px + w_eff - nx;
          cy <= (py >= ny) ? py - ny : py + h_eff - ny;
        end
        // scan counts: full (unreduced) window, from fx, fy and the level
        i <= 13'(fx) * 13'(lvl) * 13'd2 - 13'd1;
        j <= 13'(fy) * 13'(lvl) * 13'd2 - 13'd1;
      end
      wbb_pkg::S_SCAN: begin
        if (i == 13'd0) begin
          i <= 13'(fx) * 13'(lvl) * 13'd2 - 13'd1;
          j <= j - 13'd1;
          // next row starts again at the window's first column
          cx <= sx;
          cy <= (cy + 13'd1 >= h_eff) ? 13'd0 : cy + 13'd1;
        end else begin
          i <= i - 13'd1;
          cx <= (cx + 13'd1 >= w_eff) ? 13'd0 : cx + 13'd1;
        end
      end
      default: ;
    endcase
    if (acc_en)
      for (int c = 0; c < 4; c++) sum[c] <= sum[c] + SW'(rd_data[8*c +: 8]);
    if (state == wbb_pkg::S_DRAIN || state == wbb_pkg::S_OUT) begin
      for (int c = 0; c < 4; c++) begin
        if (zero_res) res[c] <= 8'd0;
        else if (pass) res[c] <= rd_data[8*c +: 8];
        else if (state == wbb_pkg::S_OUT) res[c] <= quot[c][7:0];
      end
    end
  end

  for (genvar g = 0; g < 4; g++) begin : g_div
    wbb_divider #(.NW(SW), .DW(24)) u_div (
      .clk(clk), .rst(rst), .start(div_start), .numer(sum[g]),
      .denom(cnt), .done(div_done[g]), .quot(quot[g])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) out_valid <= 1'b0;
    else if (state == wbb_pkg::S_OUT) out_valid <= 1'b1;
    else if (!out_stall) out_valid <= 1'b0;
  end

  assign out_red   = res[0];
  assign out_green = res[1];
  assign out_blue  = res[2];
  assign out_alpha = res[3];

  logic unused;
  assign unused = ^{acc_last, div_done[3:1], cnt[23], NWW[0]};
endmodule

// File: rtl/wbb_checker.sv
// Port-level checker for the wrapped box blur unit, bound to the top level.
// Depends on wrapped_box_blur_rgba_unit.
module wbb_checker (
  input logic       clk,
  input logic       rst,
  input logic       in_valid,
  input logic       in_stall,
  input logic       command,
  input logic       out_valid,
  input logic       out_stall,
  input logic [7:0] out_red
);
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(out_red)) else $error("out word dropped");
  a_busy: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> in_stall) else $error("input taken while result pending");
  a_blur: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall && command |=> in_stall) else $error("blur not started");
  a_load: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall && !command |=> !out_valid) else $error("load produced word");
endmodule

bind wrapped_box_blur_rgba_unit wbb_checker u_chk (
  .clk(clk), .rst(rst), .in_valid(in_valid), .in_stall(in_stall), .command(command),
  .out_valid(out_valid), .out_stall(out_stall), .out_red(out_red)
);

// File: test/wrapped_box_blur_rgba_unit_tb.sv
// Self-checking testbench for wrapped_box_blur_rgba_unit: load/blur words with a local
// frame model, field checks on the output words. Depends on wbb_pkg and the unit RTL.
`timescale 1ns / 100ps

module wrapped_box_blur_rgba_unit_tb;
  typedef struct {
    logic       cmd;
    logic [8:0] x;
    logic [8:0] y;
    logic [7:0] r, g, b, a;
  } word_t;

  typedef struct {
    logic [7:0] r, g, b, a;
  } rgba_t;

  logic clk = 0;
  logic rst = 1;
  logic cfg_we = 0;
  logic [1:0] cfg_index = wbb_pkg::RegWidth;
  logic [9:0] cfg_data = '0;
  logic in_valid = 0;
  logic in_stall;
  logic command = wbb_pkg::CmdLoad;
  logic [8:0] pixel_x = '0, pixel_y = '0;
  logic [7:0] in_red = '0, in_green = '0, in_blue = '0, in_alpha = '0;
  logic out_valid;
  logic out_stall = 0;
  logic [7:0] out_red, out_green, out_blue, out_alpha;

  wrapped_box_blur_rgba_unit dut (.*);

  always #5 clk = ~clk;

  word_t pending_words[$];
  rgba_t expected_pixels[$];
  bit [31:0] frame_mem [wbb_pkg::MaxWidthDef*wbb_pkg::MaxHeightDef];
  int unsigned width_reg = 256, height_reg = 256, level_reg = 5, source_reg = 1;
  int snd_idle = 0, rcv_idle = 0;
  int hold_ask = 0, hold_done = 0, hold_cnt = 0;
  int errors = 0, quiet_cycles = 0;
  word_t cur;

  function automatic int unsigned clamp_dim(int unsigned v, int unsigned lim);
    if (v == 0) return 1;
    if (v > lim) return lim;
    return v;
  endfunction

  function automatic rgba_t blur_pixel(logic [8:0] qx, logic [8:0] qy);
    int unsigned w, h, lvl, fx, fy, nx, ny, px, py, cx, cy, cnt;
    int unsigned s[4];
    bit [31:0] p;
    rgba_t res;
    res = '{8'd0, 8'd0, 8'd0, 8'd0};
    s = '{0, 0, 0, 0};
    if (source_reg == 0) return res;
    w = clamp_dim(width_reg, wbb_pkg::MaxWidthDef);
    h = clamp_dim(height_reg, wbb_pkg::MaxHeightDef);
    px = qx % w;
    py = qy % h;
    lvl = (level_reg > wbb_pkg::LevelMax) ? wbb_pkg::LevelMax : level_reg;
    if (lvl == 0) begin
      p = frame_mem[py*wbb_pkg::MaxWidthDef + px];
      return '{p[7:0], p[15:8], p[23:16], p[31:24]};
    end
    fx = (w / wbb_pkg::SizeStep < 1) ? 1 : w / wbb_pkg::SizeStep;
    fy = (h / wbb_pkg::SizeStep < 1) ? 1 : h / wbb_pkg::SizeStep;
    nx = lvl * fx;
    ny = lvl * fy;
    cy = (py + h - (ny % h)) % h;
    for (int j = 0; j < 2*ny; j++) begin
      cx = (px + w - (nx % w)) % w;
      for (int i = 0; i < 2*nx; i++) begin
        p = frame_mem[cy*wbb_pkg::MaxWidthDef + cx];
        for (int c = 0; c < 4; c++) s[c] += p[8*c +: 8];
        cx = (cx + 1 >= w) ? 0 : cx + 1;
      end
      cy = (cy + 1 >= h) ? 0 : cy + 1;
    end
    cnt = 4 * nx * ny;
    res.r = 8'(s[0] / cnt);
    res.g = 8'(s[1] / cnt);
    res.b = 8'(s[2] / cnt);
    res.a = 8'(s[3] / cnt);
    return res;
  endfunction

  // sender: predict on acceptance, then offer the next word or idle
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 0;
    end else begin
      if (in_valid && !in_stall) begin
        if (cur.cmd == wbb_pkg::CmdLoad)
          frame_mem[cur.y*wbb_pkg::MaxWidthDef + cur.x] = {cur.a, cur.b, cur.g, cur.r};
        else
          expected_pixels.push_back(blur_pixel(cur.x, cur.y));
      end
      if (!in_valid || !in_stall) begin
        if (pending_words.size() > 0 && $urandom_range(99) >= snd_idle) begin
          cur = pending_words.pop_front();
          in_valid <= 1;
          command <= cur.cmd;
          pixel_x <= cur.x;
          pixel_y <= cur.y;
          in_red <= cur.r;
          in_green <= cur.g;
          in_blue <= cur.b;
          in_alpha <= cur.a;
        end else begin
          in_valid <= 0;
        end
      end
    end
  end

  // receiver: random stall plus an occasional long hold-off
  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 0;
    end else if (hold_cnt > 0) begin
      out_stall <= 1;
      hold_cnt <= hold_cnt - 1;
    end else if (hold_done != hold_ask) begin
      hold_done <= hold_ask;
      hold_cnt <= 400;
      out_stall <= 1;
    end else begin
      out_stall <= ($urandom_range(99) < rcv_idle);
    end
  end

  always @(posedge clk) begin
    rgba_t e;
    if (!rst && out_valid && !out_stall) begin
      if (expected_pixels.size() == 0) begin
        $display("%0t: unexpected word r=%h g=%h b=%h a=%h", $time,
                 out_red, out_green, out_blue, out_alpha);
        errors++;
      end else begin
        e = expected_pixels.pop_front();
        if (out_red !== e.r) begin
          $display("%0t: red exp %h got %h", $time, e.r, out_red); errors++;
        end
        if (out_green !== e.g) begin
          $display("%0t: green exp %h got %h", $time, e.g, out_green); errors++;
        end
        if (out_blue !== e.b) begin
          $display("%0t: blue exp %h got %h", $time, e.b, out_blue); errors++;
        end
        if (out_alpha !== e.a) begin
          $display("%0t: alpha exp %h got %h", $time, e.a, out_alpha); errors++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= 60000) begin
      $display("Regression FAIL");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic write_reg(logic [1:0] idx, int unsigned val);
    @(posedge clk);
    cfg_we <= 1;
    cfg_index <= idx;
    cfg_data <= val[9:0];
    case (idx)
      wbb_pkg::RegWidth:  width_reg = val & 10'h3FF;
      wbb_pkg::RegHeight: height_reg = val & 10'h3FF;
      wbb_pkg::RegLevel:  level_reg = val & 5'h1F;
      default:            source_reg = val & 1;
    endcase
    @(posedge clk);
    cfg_we <= 0;
  endtask

  function automatic logic [7:0] chan();
    case ($urandom_range(3))
      0: return 8'h00;
      1: return 8'hFF;
      default: return 8'($urandom_range(255));
    endcase
  endfunction

  task automatic push(logic cmd, int unsigned x, int unsigned y);
    word_t wd;
    wd.cmd = cmd;
    wd.x = 9'(x);
    wd.y = 9'(y);
    wd.r = chan();
    wd.g = chan();
    wd.b = chan();
    wd.a = chan();
    pending_words.push_back(wd);
  endtask

  task automatic drain();
    do @(posedge clk);
    while (pending_words.size() != 0 || in_valid || expected_pixels.size() != 0);
    repeat (50) @(posedge clk);
  endtask

  // one setting: program registers, load the whole frame, then mixed words
  task automatic run_phase(int unsigned w, int unsigned h, int unsigned lvl,
                           int unsigned src, int n_rand, bit hold);
    int unsigned ew, eh;
    write_reg(wbb_pkg::RegWidth, w);
    write_reg(wbb_pkg::RegHeight, h);
    write_reg(wbb_pkg::RegLevel, lvl);
    write_reg(wbb_pkg::RegSource, src);
    ew = clamp_dim(w, wbb_pkg::MaxWidthDef);
    eh = clamp_dim(h, wbb_pkg::MaxHeightDef);
    for (int y = 0; y < eh; y++)
      for (int x = 0; x < ew; x++) push(wbb_pkg::CmdLoad, x, y);
    push(wbb_pkg::CmdBlur, 0, 0);
    push(wbb_pkg::CmdBlur, 511, 511);
    for (int k = 0; k < n_rand; k++) begin
      if ($urandom_range(99) < 55) begin
        if ($urandom_range(99) < 80)
          push(wbb_pkg::CmdBlur, $urandom_range(ew - 1), $urandom_range(eh - 1));
        else
          push(wbb_pkg::CmdBlur, $urandom_range(511), $urandom_range(511));
      end else begin
        if ($urandom_range(99) < 85)
          push(wbb_pkg::CmdLoad, $urandom_range(ew - 1), $urandom_range(eh - 1));
        else
          push(wbb_pkg::CmdLoad, $urandom_range(511), $urandom_range(511));
      end
    end
    if (hold) hold_ask++;
    drain();
  endtask

  initial begin
    int unsigned lvl;
    repeat (4) @(posedge clk);
    rst <= 0;
    snd_idle = 8;
    rcv_idle = 51;
    // directed: extremes of size, level, pass through, no source
    run_phase(1, 1, 1, 1, 4, 0);
    run_phase(0, 512, 30, 1, 2, 0);
    run_phase(1023, 1, 31, 1, 1, 0);
    run_phase(7, 5, 0, 1, 8, 0);
    run_phase(9, 6, 3, 0, 6, 0);
    for (int k = 0; k < 10; k++) begin
      if (k == 3) begin
        snd_idle = 51;
        rcv_idle = 8;
      end else if (k == 6) begin
        snd_idle = 0;
        rcv_idle = 0;
      end
      case ($urandom_range(9))
        0: lvl = 0;
        1: lvl = $urandom_range(31, 8);
        default: lvl = $urandom_range(4, 1);
      endcase
      run_phase($urandom_range(8, 1), $urandom_range(8, 1), lvl,
                ($urandom_range(9) != 0), 35, (k == 4 || k == 8));
    end
    if (errors == 0)
      $display("Regression PASS");
    else
      $display("Regression FAIL");
    $finish;
  end
endmodule
